[rtl/dpt_pkg.sv]
// Shared types and constants for the duotone pixel tint pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package dpt_pkg;

	// one color channel and a blue/green/red triple (index 0 blue, 1 green, 2 red)
	typedef logic [7:0] chan_t;
	typedef chan_t [2:0] rgb_t;

	localparam int unsigned CH_BLUE  = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_RED   = 2;

	// filter modes; code 7 is unused and behaves as pass-through
	typedef enum logic [2:0] {
		MODE_PASS      = 3'd0,
		MODE_TINT_DROP = 3'd1,
		MODE_TINT_KEEP = 3'd2,
		MODE_CHROMA    = 3'd3,
		MODE_LUMA      = 3'd4,
		MODE_GRAY      = 3'd5,
		MODE_BLEND     = 3'd6
	} mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_FILTER_MODE  = 2'd0,
		REG_PIXEL_FORMAT = 2'd1,
		REG_BACKGROUND   = 2'd2,
		REG_FOREGROUND   = 2'd3
	} reg_idx_t;

	localparam int unsigned CFG_DATA_W = 24;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] BG_RESET = 24'h000000;
	localparam logic [CFG_DATA_W-1:0] FG_RESET = 24'hFFFFFF;

	localparam chan_t CHAN_MAX = 8'hFF;

	// luma weights (per mille) and gray weights (percent)
	localparam int unsigned LUMA_KR = 299;
	localparam int unsigned LUMA_KG = 587;
	localparam int unsigned LUMA_KB = 114;
	localparam int unsigned GRAY_KR = 30;
	localparam int unsigned GRAY_KG = 59;
	localparam int unsigned GRAY_KB = 11;

	// divide by constant through reciprocal multiply; exact over the sum ranges used
	localparam int unsigned LUMA_SUM_W   = 18;   // 255 * 1000 fits
	localparam int unsigned LUMA_SHIFT   = 28;
	localparam int unsigned LUMA_RECIP   = 268436; // ceil(2^28 / 1000)
	localparam int unsigned LUMA_PROD_W  = 37;
	localparam int unsigned GRAY_SUM_W   = 15;   // 255 * 100 fits
	localparam int unsigned GRAY_SHIFT   = 22;
	localparam int unsigned GRAY_RECIP   = 41944;  // ceil(2^22 / 100)
	localparam int unsigned GRAY_PROD_W  = 31;
	localparam int unsigned BLEND_SUM_W  = 16;   // 255 * 255 + 127 fits
	localparam int unsigned BLEND_SHIFT  = 24;
	localparam int unsigned BLEND_RECIP  = 65794;  // ceil(2^24 / 255)
	localparam int unsigned BLEND_PROD_W = 33;
	localparam int unsigned BLEND_ROUND  = 127;

	// live configuration seen by the datapath
	typedef struct packed {
		mode_t mode;
		logic  fmt32;
		rgb_t  bk;
		rgb_t  fg;
	} cfg_t;

	// one pixel beat
	typedef struct packed {
		rgb_t  px;
		chan_t alpha;
		logic  last;
	} pix_t;

	// front-end result: pixel plus luma and gray levels
	typedef struct packed {
		pix_t  pix;
		chan_t luma;
		chan_t gray;
	} lum_t;

	// tint-stage result handed to the blend stage
	typedef struct packed {
		rgb_t  src;
		logic  blend_en;
		chan_t alpha;
		chan_t oa;
		logic  last;
	} blend_in_t;

endpackage

`default_nettype wire

[rtl/dpt_cfg.sv]
// Configuration register file for the duotone pixel tint block.
// Depends on dpt_pkg.
`default_nettype none

module dpt_cfg
	import dpt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	mode_t mode_q;
	logic  fmt32_q;
	logic [CFG_DATA_W-1:0] bg_q;
	logic [CFG_DATA_W-1:0] fg_q;
	logic wr;

	// always able to take a write beat
	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PASS;
			fmt32_q <= 1'b1;
			bg_q    <= BG_RESET;
			fg_q    <= FG_RESET;
		end else if (wr) begin
			case (reg_idx_t'(cfg_index))
				REG_FILTER_MODE:  mode_q  <= mode_t'(cfg_data[2:0]);
				REG_PIXEL_FORMAT: fmt32_q <= cfg_data[0];
				REG_BACKGROUND:   bg_q    <= cfg_data;
				REG_FOREGROUND:   fg_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack colors: blue in the top byte, red in the bottom
	always_comb begin
		cfg.mode  = mode_q;
		cfg.fmt32 = fmt32_q;
		cfg.bk[CH_BLUE]  = bg_q[23:16];
		cfg.bk[CH_GREEN] = bg_q[15:8];
		cfg.bk[CH_RED]   = bg_q[7:0];
		cfg.fg[CH_BLUE]  = fg_q[23:16];
		cfg.fg[CH_GREEN] = fg_q[15:8];
		cfg.fg[CH_RED]   = fg_q[7:0];
	end

endmodule

`default_nettype wire

[rtl/dpt_luma.sv]
// Front end, stages 1-2: weighted channel sums, then luma and gray levels
// by reciprocal multiply. Depends on dpt_pkg.
`default_nettype none

module dpt_luma
	import dpt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire pix_t pix_in,
	output logic      valid_out,
	output lum_t      lum_out
);

	logic                   v_s1;
	pix_t                   pix_s1;
	logic [LUMA_SUM_W-1:0]  luma_sum_s1;
	logic [GRAY_SUM_W-1:0]  gray_sum_s1;
	logic                   v_s2;
	lum_t                   lum_s2;
	logic [LUMA_SUM_W-1:0]  luma_sum;
	logic [GRAY_SUM_W-1:0]  gray_sum;
	logic [LUMA_PROD_W-1:0] luma_prod;
	logic [GRAY_PROD_W-1:0] gray_prod;

	// weighted sums by constants
	assign luma_sum =
		LUMA_SUM_W'(pix_in.px[CH_RED])   * LUMA_SUM_W'(LUMA_KR) +
		LUMA_SUM_W'(pix_in.px[CH_GREEN]) * LUMA_SUM_W'(LUMA_KG) +
		LUMA_SUM_W'(pix_in.px[CH_BLUE])  * LUMA_SUM_W'(LUMA_KB);
	assign gray_sum =
		GRAY_SUM_W'(pix_in.px[CH_RED])   * GRAY_SUM_W'(GRAY_KR) +
		GRAY_SUM_W'(pix_in.px[CH_GREEN]) * GRAY_SUM_W'(GRAY_KG) +
		GRAY_SUM_W'(pix_in.px[CH_BLUE])  * GRAY_SUM_W'(GRAY_KB);

	// divide by 1000 and by 100
	assign luma_prod = LUMA_PROD_W'(luma_sum_s1) * LUMA_PROD_W'(LUMA_RECIP);
	assign gray_prod = GRAY_PROD_W'(gray_sum_s1) * GRAY_PROD_W'(GRAY_RECIP);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1       <= pix_in;
			luma_sum_s1  <= luma_sum;
			gray_sum_s1  <= gray_sum;
			lum_s2.pix   <= pix_s1;
			lum_s2.luma  <= luma_prod[LUMA_SHIFT +: 8];
			lum_s2.gray  <= gray_prod[GRAY_SHIFT +: 8];
		end
	end

	assign valid_out = v_s2;
	assign lum_out   = lum_s2;

endmodule

`default_nettype wire

[rtl/dpt_tint.sv]
// Tint stages 3-4: per-channel tint and chroma products, then the mode
// select that picks the color fed to the blend. Depends on dpt_pkg.
`default_nettype none

module dpt_tint
	import dpt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire cfg_t cfg,
	input  wire logic valid_in,
	input  wire lum_t lum_in,
	output logic      valid_out,
	output blend_in_t bl_out
);

	logic      v_s3;
	lum_t      lum_s3;
	rgb_t      tq_s3;   // low byte of floor(d * (255 - c) / 256)
	rgb_t      ch_s3;   // chroma tint per channel
	logic      v_s4;
	blend_in_t bl_s4;

	logic signed [8:0]  d   [3];
	logic signed [17:0] t   [3];
	logic [15:0]        chs [3];
	chan_t              c   [3];
	chan_t              w   [3];
	rgb_t               tq;
	rgb_t               chq;
	rgb_t               f;
	chan_t              wb;
	logic               tinted;
	logic               keep_a;
	blend_in_t          bl;

	// stage 3: products per channel
	assign wb = CHAN_MAX - lum_in.pix.px[CH_BLUE];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c[i] = (cfg.mode == MODE_LUMA) ? lum_in.luma : lum_in.pix.px[i];
			w[i] = CHAN_MAX - c[i];
			d[i] = $signed({1'b0, cfg.fg[i]}) - $signed({1'b0, cfg.bk[i]});
			t[i] = 18'(d[i]) * 18'($signed({1'b0, w[i]}));
			chs[i] = 16'(cfg.bk[i]) * 16'(wb) + 16'(cfg.fg[i]) * 16'(lum_in.pix.px[CH_BLUE]);
			tq[i]  = t[i][15:8];
			chq[i] = chs[i][15:8];
		end
	end

	// stage 4: finish tint and choose the blend source
	always_comb begin
		for (int i = 0; i < 3; i++)
			f[i] = (cfg.mode == MODE_CHROMA) ? ch_s3[i] : cfg.fg[i] - tq_s3[i];
		tinted = 1'b0;
		keep_a = 1'b0;
		bl.src = lum_s3.pix.px;
		case (cfg.mode)
			MODE_TINT_DROP, MODE_CHROMA, MODE_LUMA: begin
				tinted = 1'b1;
				bl.src = f;
			end
			MODE_TINT_KEEP: begin
				tinted = 1'b1;
				keep_a = 1'b1;
				bl.src = f;
			end
			MODE_GRAY: begin
				keep_a = 1'b1;
				bl.src = {lum_s3.gray, lum_s3.gray, lum_s3.gray};
			end
			MODE_BLEND: ;
			default: keep_a = 1'b1;
		endcase
		bl.blend_en = cfg.fmt32 && (tinted || cfg.mode == MODE_BLEND);
		bl.alpha    = lum_s3.pix.alpha;
		bl.oa       = (keep_a && cfg.fmt32) ? lum_s3.pix.alpha : CHAN_MAX;
		bl.last     = lum_s3.pix.last;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= valid_in;
			v_s4 <= v_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			lum_s3 <= lum_in;
			tq_s3  <= tq;
			ch_s3  <= chq;
			bl_s4  <= bl;
		end
	end

	assign valid_out = v_s4;
	assign bl_out    = bl_s4;

endmodule

`default_nettype wire

[rtl/dpt_blend.sv]
// Blend stages 5-6: rounded alpha blend onto the background, divided by
// 255 through a reciprocal multiply, applied only when blend_en is set;
// stage 6 is the output register. Depends on dpt_pkg.
`default_nettype none

module dpt_blend
	import dpt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire cfg_t      cfg,
	input  wire logic      valid_in,
	input  wire blend_in_t bl_in,
	output logic           valid_out,
	output rgb_t           rgb_out,
	output chan_t          alpha_out,
	output logic           last_out
);

	logic      v_s5;
	blend_in_t bl_s5;
	logic [BLEND_SUM_W-1:0] sum_s5 [3];
	logic      v_s6;
	rgb_t      rgb_s6;
	chan_t     oa_s6;
	logic      last_s6;

	logic [BLEND_SUM_W-1:0]  sum  [3];
	logic [BLEND_PROD_W-1:0] prod [3];
	rgb_t                    res;
	chan_t                   na;

	// stage 5: f * a + bk * (255 - a) + 127
	assign na = CHAN_MAX - bl_in.alpha;
	always_comb begin
		for (int i = 0; i < 3; i++)
			sum[i] = BLEND_SUM_W'(bl_in.src[i]) * BLEND_SUM_W'(bl_in.alpha) +
				BLEND_SUM_W'(cfg.bk[i]) * BLEND_SUM_W'(na) +
				BLEND_SUM_W'(BLEND_ROUND);
	end

	// stage 6: divide by 255
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = BLEND_PROD_W'(sum_s5[i]) * BLEND_PROD_W'(BLEND_RECIP);
			res[i]  = bl_s5.blend_en ? prod[i][BLEND_SHIFT +: 8] : bl_s5.src[i];
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= valid_in;
			v_s6 <= v_s5;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			bl_s5   <= bl_in;
			sum_s5  <= sum;
			rgb_s6  <= res;
			oa_s6   <= bl_s5.oa;
			last_s6 <= bl_s5.last;
		end
	end

	assign valid_out = v_s6;
	assign rgb_out   = rgb_s6;
	assign alpha_out = oa_s6;
	assign last_out  = last_s6;

endmodule

`default_nettype wire

[rtl/duotone_pixel_tint.sv]
// Duotone pixel tint: per-pixel color filter on a BGRA stream, one result
// beat for every input beat. Depends on dpt_pkg, dpt_cfg, dpt_luma,
// dpt_tint and dpt_blend.
//
// The block takes one pixel per clock and passes it through six register
// stages: two form the luma and gray levels, two form the tint, and two
// blend onto the background, the divide by 255 landing in the output
// register. Every stage but the fourth holds multiplies; throughput is
// one pixel per cycle for as long as out_stall stays low. When the output
// beat is held, the whole pipeline freezes and in_stall rises in the same
// cycle. Registers must be written through the cfg port only while no
// pixel is in flight; the block itself does not enforce this.
`default_nettype none

module duotone_pixel_tint
	import dpt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// pixel input
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            in_blue,
	input  wire logic [7:0]            in_green,
	input  wire logic [7:0]            in_red,
	input  wire logic [7:0]            in_alpha,
	input  wire logic                  in_last,
	// pixel output
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 out_blue,
	output logic [7:0]                 out_green,
	output logic [7:0]                 out_red,
	output logic [7:0]                 out_alpha,
	output logic                       out_last
);

	cfg_t      cfg;
	pix_t      pix_in;
	logic      en;
	logic      lum_valid;
	lum_t      lum;
	logic      bl_valid;
	blend_in_t bl;
	rgb_t      rgb;

	// advance everything unless the output beat is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_comb begin
		pix_in.px[CH_BLUE]  = in_blue;
		pix_in.px[CH_GREEN] = in_green;
		pix_in.px[CH_RED]   = in_red;
		pix_in.alpha        = in_alpha;
		pix_in.last         = in_last;
	end

	dpt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dpt_luma u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (in_valid),
		.pix_in    (pix_in),
		.valid_out (lum_valid),
		.lum_out   (lum)
	);

	dpt_tint u_tint (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.valid_in  (lum_valid),
		.lum_in    (lum),
		.valid_out (bl_valid),
		.bl_out    (bl)
	);

	dpt_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.valid_in  (bl_valid),
		.bl_in     (bl),
		.valid_out (out_valid),
		.rgb_out   (rgb),
		.alpha_out (out_alpha),
		.last_out  (out_last)
	);

	assign out_blue  = rgb[CH_BLUE];
	assign out_green = rgb[CH_GREEN];
	assign out_red   = rgb[CH_RED];

endmodule

`default_nettype wire

[verif/duotone_pixel_tint_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for duotone_pixel_tint: random BGRA beats under every filter mode and format.
// Needs dpt_pkg and the duotone_pixel_tint RTL; a shadow filter model predicts each output beat.

module duotone_pixel_tint_tb;
	import dpt_pkg::*;

	localparam int unsigned DRAIN_CYCLES = 10;	// six-stage pipe plus margin
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_BEATS = 45;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic       last;
	} bgra_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            in_blue = '0;
	logic [7:0]            in_green = '0;
	logic [7:0]            in_red = '0;
	logic [7:0]            in_alpha = '0;
	logic                  in_last = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            out_blue;
	logic [7:0]            out_green;
	logic [7:0]            out_red;
	logic [7:0]            out_alpha;
	logic                  out_last;

	// shadow copy of the filter registers
	logic [2:0]  mode_sel = MODE_PASS;
	logic        fmt32 = 1'b1;
	logic [23:0] bg_color = BG_RESET;
	logic [23:0] fg_color = FG_RESET;

	bgra_t       source_q[$];
	bgra_t       filtered_q[$];
	bgra_t       on_wire;
	bit          steady_flow = 1'b0;
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;

	duotone_pixel_tint dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_blue   (in_blue),
		.in_green  (in_green),
		.in_red    (in_red),
		.in_alpha  (in_alpha),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_blue  (out_blue),
		.out_green (out_green),
		.out_red   (out_red),
		.out_alpha (out_alpha),
		.out_last  (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// fg - floor((fg - bk) * (255 - c) / 256)
	function automatic int unsigned tint_chan(int unsigned fgc, int unsigned bkc, int unsigned c);
		int t;
		t = (int'(fgc) - int'(bkc)) * (255 - int'(c));
		return unsigned'((int'(fgc) - (t >>> 8)) & 255);
	endfunction

	// rounded mix of f over bk by alpha a, divided by 255
	function automatic int unsigned blend_chan(int unsigned f, int unsigned bkc, int unsigned a);
		return ((f * a + (255 - a) * bkc + 127) / 255) & 255;
	endfunction

	// expected output beat for one input beat under the current registers
	function automatic bgra_t duotone_filter(bgra_t p);
		bgra_t       r;
		int unsigned px[3], bk[3], fg[3], f[3], res[3];
		int unsigned a, y, oa;
		bit          tinted;
		px[CH_BLUE] = 32'(p.blue);
		px[CH_GREEN] = 32'(p.green);
		px[CH_RED] = 32'(p.red);
		a = 32'(p.alpha);
		oa = fmt32 ? a : 255;
		tinted = 1'b0;
		for (int i = 0; i < 3; i++) begin
			bk[i] = 32'(bg_color[16 - 8 * i +: 8]);
			fg[i] = 32'(fg_color[16 - 8 * i +: 8]);
			f[i] = px[i];
			res[i] = px[i];
		end
		case (mode_sel)
			MODE_TINT_DROP, MODE_TINT_KEEP: begin
				for (int i = 0; i < 3; i++)
					f[i] = tint_chan(fg[i], bk[i], px[i]);
				tinted = 1'b1;
			end
			MODE_CHROMA: begin
				// weight taken from the blue channel for all three outputs
				for (int i = 0; i < 3; i++)
					f[i] = ((bk[i] * (255 - px[CH_BLUE]) + fg[i] * px[CH_BLUE]) >> 8) & 255;
				tinted = 1'b1;
			end
			MODE_LUMA: begin
				y = (px[CH_RED] * LUMA_KR + px[CH_GREEN] * LUMA_KG + px[CH_BLUE] * LUMA_KB) / 1000;
				for (int i = 0; i < 3; i++)
					f[i] = tint_chan(fg[i], bk[i], y);
				tinted = 1'b1;
			end
			MODE_GRAY: begin
				y = (px[CH_RED] * GRAY_KR + px[CH_GREEN] * GRAY_KG + px[CH_BLUE] * GRAY_KB) / 100;
				for (int i = 0; i < 3; i++)
					res[i] = y & 255;
			end
			MODE_BLEND: begin
				// 24-bit pixels pass untouched
				if (fmt32) begin
					for (int i = 0; i < 3; i++) begin
						if (a == 0)
							res[i] = bk[i];
						else if (a != 255)
							res[i] = blend_chan(px[i], bk[i], a);
					end
					oa = 255;
				end
			end
			default: ;
		endcase
		// tinted color goes over the background by the real alpha in 32-bit format
		if (tinted) begin
			for (int i = 0; i < 3; i++) begin
				if (!fmt32 || a == 255)
					res[i] = f[i];
				else if (a == 0)
					res[i] = bk[i];
				else
					res[i] = blend_chan(f[i], bk[i], a);
			end
			if (mode_sel != MODE_TINT_KEEP)
				oa = 255;
		end
		r.blue = 8'(res[CH_BLUE]);
		r.green = 8'(res[CH_GREEN]);
		r.red = 8'(res[CH_RED]);
		r.alpha = 8'(oa);
		r.last = p.last;
		return r;
	endfunction

	function automatic int unsigned field_diff(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// alpha and channels lean toward their extremes
	function automatic logic [7:0] biased_byte(int unsigned odds);
		case ($urandom_range(odds - 1))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			3: return 8'd254;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic bgra_t random_pixel();
		bgra_t p;
		p.blue = biased_byte(12);
		p.green = biased_byte(12);
		p.red = biased_byte(12);
		p.alpha = biased_byte(6);
		p.last = ($urandom_range(15) == 0);
		return p;
	endfunction

	function automatic logic [23:0] random_color();
		case ($urandom_range(3))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	// register write, shadow copy updated once the beat is taken
	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_FILTER_MODE:  mode_sel = val[2:0];
			REG_PIXEL_FORMAT: fmt32 = val[0];
			REG_BACKGROUND:   bg_color = val[23:0];
			REG_FOREGROUND:   fg_color = val[23:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// every queued beat sent and every output beat seen, then let the pipe drain
	task automatic wait_idle();
		@(negedge clk);
		while (source_q.size() != 0 || in_valid || filtered_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// pixel driver: predict on accept, hold payload while stalled
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			filtered_q.push_back(duotone_filter(on_wire));
		if (!in_valid || !in_stall) begin
			if (source_q.size() != 0 && (steady_flow || $urandom_range(99) >= 21)) begin
				on_wire = source_q.pop_front();
				in_valid <= 1'b1;
				in_blue <= on_wire.blue;
				in_green <= on_wire.green;
				in_red <= on_wire.red;
				in_alpha <= on_wire.alpha;
				in_last <= on_wire.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output monitor and random back-pressure
	always @(posedge clk) begin
		bgra_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got = {out_blue, out_green, out_red, out_alpha, out_last};
			if (filtered_q.size() == 0) begin
				$display("%0t ns: output beat with none expected, got %h", $time, got);
				mismatch_cnt++;
			end else begin
				want = filtered_q.pop_front();
				mismatch_cnt += field_diff("out_blue", want.blue, got.blue);
				mismatch_cnt += field_diff("out_green", want.green, got.green);
				mismatch_cnt += field_diff("out_red", want.red, got.red);
				mismatch_cnt += field_diff("out_alpha", want.alpha, got.alpha);
				mismatch_cnt += field_diff("out_last", 8'(want.last), 8'(got.last));
			end
		end
		out_stall <= !steady_flow && ($urandom_range(99) < 21);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("duotone_pixel_tint: mismatch");
			$finish;
		end
	end

	initial begin
		int unsigned m, ph, k;
		bgra_t p;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: each mode on corner pixels, tint colors on both sides of the background
		write_reg(REG_PIXEL_FORMAT, 24'd1);
		write_reg(REG_BACKGROUND, 24'hFF0040);
		write_reg(REG_FOREGROUND, 24'h00FF80);
		for (m = 0; m < 8; m++) begin
			wait_idle();
			write_reg(REG_FILTER_MODE, 24'(m));
			@(negedge clk);
			source_q.push_back('{blue: 8'd0, green: 8'd255, red: 8'd128, alpha: 8'd255, last: 1'b0});
			source_q.push_back('{blue: 8'd255, green: 8'd0, red: 8'd1, alpha: 8'd0, last: 1'b1});
			source_q.push_back('{blue: 8'd77, green: 8'd200, red: 8'd255, alpha: 8'd90, last: 1'b0});
		end

		// random: every mode in both formats, colors at the extremes and random
		for (ph = 0; ph < 16; ph++) begin
			wait_idle();
			write_reg(REG_FILTER_MODE, 24'(ph >> 1));
			write_reg(REG_PIXEL_FORMAT, 24'(ph & 1));
			case (ph % 4)
				0: begin
					write_reg(REG_BACKGROUND, 24'h000000);
					write_reg(REG_FOREGROUND, 24'hFFFFFF);
				end
				1: begin
					write_reg(REG_BACKGROUND, 24'hFFFFFF);
					write_reg(REG_FOREGROUND, 24'h000000);
				end
				default: begin
					write_reg(REG_BACKGROUND, random_color());
					write_reg(REG_FOREGROUND, random_color());
				end
			endcase
			@(negedge clk);
			// one full phase with no gaps on either side
			steady_flow = (ph == 9);
			for (k = 0; k < PHASE_BEATS; k++) begin
				p = random_pixel();
				source_q.push_back(p);
			end
		end

		wait_idle();
		if (mismatch_cnt == 0)
			$display("duotone_pixel_tint: match");
		else
			$display("duotone_pixel_tint: mismatch");
		$finish;
	end

endmodule

[files.f]
rtl/dpt_pkg.sv
rtl/dpt_cfg.sv
rtl/dpt_luma.sv
rtl/dpt_tint.sv
rtl/dpt_blend.sv
rtl/duotone_pixel_tint.sv
verif/duotone_pixel_tint_tb.sv
